// ===== src/lldp_pkg.sv =====
// Shared types and constants for the LLDP TLV stream parser.
// No dependencies; imported by every module of the block.
package lldp_pkg;

  localparam logic [15:0] ETYPE_RESET = 16'h88CC;
  localparam logic [3:0]  TLV_START   = 4'd14;
  localparam logic [3:0]  SRC_START   = 4'd6;
  localparam logic [3:0]  ETYPE_POS0  = 4'd12;
  localparam logic [3:0]  ETYPE_POS1  = 4'd13;
  localparam logic [6:0]  END_TLV     = 7'd0;

  // byte labels
  localparam logic [2:0] K_DST     = 3'd0;
  localparam logic [2:0] K_SRC     = 3'd1;
  localparam logic [2:0] K_ETYPE   = 3'd2;
  localparam logic [2:0] K_THDR    = 3'd3;
  localparam logic [2:0] K_TVAL    = 3'd4;
  localparam logic [2:0] K_END     = 3'd5;
  localparam logic [2:0] K_IGN     = 3'd6;
  localparam logic [2:0] K_NONLLDP = 3'd7;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_VALUE,
    PH_END1,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] idx;
    logic [6:0] tk;
    logic [8:0] ts;
    logic [8:0] voff;
    logic       vfin;
    logic       lldp;
    logic       endr;
    logic       trunc;
  } res_t;

endpackage

// ===== src/lldp_walker.sv =====
// Per-frame parse state and byte labelling logic.
// Depends on lldp_pkg; one transaction is labelled on each fire.
module lldp_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  lldp_pkg::item_t      item,
  input  logic [15:0]          match_ethertype,
  output lldp_pkg::res_t       res
);
  import lldp_pkg::*;

  logic [3:0] frame_pos, frame_pos_next;
  phase_t     parse_phase, parse_phase_next;
  logic [7:0] type_high_byte, type_high_byte_next;
  logic [6:0] cur_tlv_kind, cur_tlv_kind_next;
  logic       length_high_bit, length_high_bit_next;
  logic [8:0] cur_tlv_size, cur_tlv_size_next;
  logic [8:0] value_count, value_count_next;
  logic       lldp_flag, lldp_flag_next;
  logic       end_flag, end_flag_next;

  // state seen by this byte, after a frame start clears it
  logic [3:0] pos_c;
  phase_t     ph_c;
  logic [7:0] thb_c;
  logic [6:0] tk_c;
  logic       lhb_c;
  logic [8:0] ts_c;
  logic [8:0] vc_c;
  logic       lldp_c;
  logic       end_c;
  logic [9:0] vc_inc;
  logic [3:0] src_idx;

  always_comb begin
    pos_c  = item.first ? '0 : frame_pos;
    ph_c   = item.first ? PH_HDR0 : parse_phase;
    thb_c  = item.first ? '0 : type_high_byte;
    tk_c   = item.first ? '0 : cur_tlv_kind;
    lhb_c  = item.first ? 1'b0 : length_high_bit;
    ts_c   = item.first ? '0 : cur_tlv_size;
    vc_c   = item.first ? '0 : value_count;
    lldp_c = item.first ? 1'b0 : lldp_flag;
    end_c  = item.first ? 1'b0 : end_flag;

    vc_inc  = {1'b0, vc_c} + 10'd1;
    src_idx = pos_c - SRC_START;

    parse_phase_next     = ph_c;
    type_high_byte_next  = thb_c;
    cur_tlv_kind_next    = tk_c;
    length_high_bit_next = lhb_c;
    cur_tlv_size_next    = ts_c;
    value_count_next     = vc_c;
    lldp_flag_next       = lldp_c;
    end_flag_next        = end_c;

    res.kind = K_IGN;
    res.data = item.data;
    res.idx  = '0;
    res.tk   = '0;
    res.ts   = '0;
    res.voff = '0;
    res.vfin = 1'b0;

    if (pos_c < SRC_START) begin
      res.kind = K_DST;
      res.idx  = pos_c[2:0];
    end else if (pos_c < ETYPE_POS0) begin
      res.kind = K_SRC;
      res.idx  = src_idx[2:0];
    end else if (pos_c == ETYPE_POS0) begin
      res.kind = K_ETYPE;
      type_high_byte_next = item.data;
    end else if (pos_c == ETYPE_POS1) begin
      res.kind = K_ETYPE;
      res.idx  = 3'd1;
      lldp_flag_next = ({thb_c, item.data} == match_ethertype);
    end else if (!lldp_c) begin
      res.kind = K_NONLLDP;
    end else begin
      case (ph_c)
        PH_HDR0: begin
          cur_tlv_kind_next    = item.data[7:1];
          length_high_bit_next = item.data[0];
          cur_tlv_size_next    = '0;
          value_count_next     = '0;
          res.tk = item.data[7:1];
          if (item.data[7:1] == END_TLV) begin
            res.kind         = K_END;
            end_flag_next    = 1'b1;
            parse_phase_next = PH_END1;
          end else begin
            res.kind         = K_THDR;
            parse_phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          cur_tlv_size_next = {lhb_c, item.data};
          res.kind = K_THDR;
          res.idx  = 3'd1;
          res.tk   = tk_c;
          res.ts   = {lhb_c, item.data};
          parse_phase_next = ({lhb_c, item.data} == 9'd0) ? PH_HDR0 : PH_VALUE;
        end
        PH_VALUE: begin
          res.kind = K_TVAL;
          res.tk   = tk_c;
          res.ts   = ts_c;
          res.voff = vc_c;
          if (vc_inc >= {1'b0, ts_c}) begin
            res.vfin         = 1'b1;
            parse_phase_next = PH_HDR0;
            value_count_next = '0;
          end else begin
            value_count_next = vc_inc[8:0];
          end
        end
        PH_END1: begin
          res.kind = K_END;
          res.idx  = 3'd1;
          parse_phase_next = PH_DONE;
        end
        default: begin
          res.kind = K_IGN;
        end
      endcase
    end

    res.lldp  = lldp_flag_next;
    res.endr  = end_flag_next;
    res.trunc = item.last && lldp_flag_next && !end_flag_next;

    frame_pos_next = (pos_c < TLV_START) ? pos_c + 4'd1 : pos_c;

    // frame end: everything back to reset values for the next byte
    if (item.last) begin
      frame_pos_next       = '0;
      parse_phase_next     = PH_HDR0;
      type_high_byte_next  = '0;
      cur_tlv_kind_next    = '0;
      length_high_bit_next = 1'b0;
      cur_tlv_size_next    = '0;
      value_count_next     = '0;
      lldp_flag_next       = 1'b0;
      end_flag_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos       <= '0;
      parse_phase     <= PH_HDR0;
      type_high_byte  <= '0;
      cur_tlv_kind    <= '0;
      length_high_bit <= 1'b0;
      cur_tlv_size    <= '0;
      value_count     <= '0;
      lldp_flag       <= 1'b0;
      end_flag        <= 1'b0;
    end else if (fire) begin
      frame_pos       <= frame_pos_next;
      parse_phase     <= parse_phase_next;
      type_high_byte  <= type_high_byte_next;
      cur_tlv_kind    <= cur_tlv_kind_next;
      length_high_bit <= length_high_bit_next;
      cur_tlv_size    <= cur_tlv_size_next;
      value_count     <= value_count_next;
      lldp_flag       <= lldp_flag_next;
      end_flag        <= end_flag_next;
    end
  end

endmodule

// ===== src/lldp_out_reg.sv =====
// Result register with valid flag for the output channel.
// Depends on lldp_pkg for the result struct.
module lldp_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  lldp_pkg::res_t  res_in,
  input  logic            out_ready,
  output logic            out_valid,
  output lldp_pkg::res_t  res_out
);
  import lldp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== src/lldp_tlv_stream_parser_unit.sv =====
// LLDP TLV stream parser: labels each frame byte in one pass, one result per byte.
// The result is registered and valid in the cycle after the input transaction; throughput 1 byte/cycle,
// limited only by the result register being taken (ready while it is empty or drained).
// Synchronous active-high reset clears parse state, empties the result register and
// sets match_ethertype to 0x88CC. No clearing pass.
module lldp_tlv_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_first,
  input  logic        frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_kind,
  output logic [7:0]  byte_out,
  output logic [2:0]  byte_index,
  output logic [6:0]  tlv_kind,
  output logic [8:0]  tlv_size,
  output logic [8:0]  value_offset,
  output logic        value_final,
  output logic        is_lldp,
  output logic        end_reached,
  output logic        truncated
);
  import lldp_pkg::*;

  logic [15:0] match_ethertype;
  logic        fire;
  item_t       item;
  res_t        res_c;
  res_t        res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_ethertype <= ETYPE_RESET;
    end else if (cfg_valid) begin
      match_ethertype <= cfg_data;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign item.data  = frame_byte;
  assign item.first = frame_first;
  assign item.last  = frame_last;

  lldp_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .item            (item),
    .match_ethertype (match_ethertype),
    .res             (res_c)
  );

  lldp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_c),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign byte_kind    = res_q.kind;
  assign byte_out     = res_q.data;
  assign byte_index   = res_q.idx;
  assign tlv_kind     = res_q.tk;
  assign tlv_size     = res_q.ts;
  assign value_offset = res_q.voff;
  assign value_final  = res_q.vfin;
  assign is_lldp      = res_q.lldp;
  assign end_reached  = res_q.endr;
  assign truncated    = res_q.trunc;

endmodule

// ===== tb/lldp_label_checker.sv =====
`timescale 1ns / 1ps
// Byte-label checker for the LLDP TLV stream parser: predicts one label per accepted byte.
// Watches the input, config and result channels; depends on lldp_pkg only.
module lldp_label_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_first,
  input  logic        frame_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  byte_kind,
  input  logic [7:0]  byte_out,
  input  logic [2:0]  byte_index,
  input  logic [6:0]  tlv_kind,
  input  logic [8:0]  tlv_size,
  input  logic [8:0]  value_offset,
  input  logic        value_final,
  input  logic        is_lldp,
  input  logic        end_reached,
  input  logic        truncated,
  output int          fail_count,
  output int          pending
);
  import lldp_pkg::*;

  // predictor state, mirrors the per-frame registers of the parser
  logic [15:0] etype_match;
  logic [3:0]  pos;
  phase_t      phase;
  logic [7:0]  type_hi;
  logic [6:0]  kind_cur;
  logic        len_hi;
  logic [8:0]  size_cur;
  logic [8:0]  val_cnt;
  logic        lldp_seen;
  logic        end_seen;

  res_t label_q[$];
  res_t exp_r;
  res_t got_r;
  int   mismatches = 0;

  assign fail_count = mismatches;

  task automatic clear_frame_state();
    pos       = '0;
    phase     = PH_HDR0;
    type_hi   = '0;
    kind_cur  = '0;
    len_hi    = 1'b0;
    size_cur  = '0;
    val_cnt   = '0;
    lldp_seen = 1'b0;
    end_seen  = 1'b0;
  endtask

  task automatic enqueue_label(input res_t r);
    label_q.insert(label_q.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 100) begin
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic predict_label(input logic [7:0] b, input logic f, input logic l,
                               output res_t r);
    r      = '0;
    r.kind = K_IGN;
    r.data = b;
    if (f) begin
      clear_frame_state();
    end
    if (pos < SRC_START) begin
      r.kind = K_DST;
      r.idx  = pos[2:0];
    end else if (pos < ETYPE_POS0) begin
      r.kind = K_SRC;
      r.idx  = 3'(pos - SRC_START);
    end else if (pos == ETYPE_POS0) begin
      r.kind  = K_ETYPE;
      type_hi = b;
    end else if (pos == ETYPE_POS1) begin
      r.kind    = K_ETYPE;
      r.idx     = 3'd1;
      lldp_seen = ({type_hi, b} == etype_match);
    end else if (!lldp_seen) begin
      r.kind = K_NONLLDP;
    end else begin
      case (phase)
        PH_HDR0: begin
          kind_cur = b[7:1];
          len_hi   = b[0];
          size_cur = '0;
          val_cnt  = '0;
          r.tk     = kind_cur;
          if (kind_cur == END_TLV) begin
            r.kind   = K_END;
            end_seen = 1'b1;
            phase    = PH_END1;
          end else begin
            r.kind = K_THDR;
            phase  = PH_HDR1;
          end
        end
        PH_HDR1: begin
          size_cur = {len_hi, b};
          r.kind   = K_THDR;
          r.idx    = 3'd1;
          r.tk     = kind_cur;
          r.ts     = size_cur;
          phase    = (size_cur == '0) ? PH_HDR0 : PH_VALUE;
        end
        PH_VALUE: begin
          r.kind = K_TVAL;
          r.tk   = kind_cur;
          r.ts   = size_cur;
          r.voff = val_cnt;
          if ({1'b0, val_cnt} + 10'd1 >= {1'b0, size_cur}) begin
            r.vfin  = 1'b1;
            phase   = PH_HDR0;
            val_cnt = '0;
          end else begin
            val_cnt = val_cnt + 9'd1;
          end
        end
        PH_END1: begin
          r.kind = K_END;
          r.idx  = 3'd1;
          phase  = PH_DONE;
        end
        default: begin
          r.kind = K_IGN;
        end
      endcase
    end
    r.lldp  = lldp_seen;
    r.endr  = end_seen;
    r.trunc = l && lldp_seen && !end_seen;
    if (pos < TLV_START) begin
      pos = pos + 4'd1;
    end
    if (l) begin
      clear_frame_state();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      label_q.delete();
      clear_frame_state();
      etype_match = ETYPE_RESET;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (label_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 16'(byte_out), 16'h0);
        end else begin
          exp_r = label_q.pop_front();
          got_r = {byte_kind, byte_out, byte_index, tlv_kind, tlv_size, value_offset,
                   value_final, is_lldp, end_reached, truncated};
          check_field("byte_kind",    16'(got_r.kind),  16'(exp_r.kind));
          check_field("byte_out",     16'(got_r.data),  16'(exp_r.data));
          check_field("byte_index",   16'(got_r.idx),   16'(exp_r.idx));
          check_field("tlv_kind",     16'(got_r.tk),    16'(exp_r.tk));
          check_field("tlv_size",     16'(got_r.ts),    16'(exp_r.ts));
          check_field("value_offset", 16'(got_r.voff),  16'(exp_r.voff));
          check_field("value_final",  16'(got_r.vfin),  16'(exp_r.vfin));
          check_field("is_lldp",      16'(got_r.lldp),  16'(exp_r.lldp));
          check_field("end_reached",  16'(got_r.endr),  16'(exp_r.endr));
          check_field("truncated",    16'(got_r.trunc), 16'(exp_r.trunc));
        end
      end
      if (cfg_valid && cfg_ready) begin
        etype_match = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_label(frame_byte, frame_first, frame_last, exp_r);
        enqueue_label(exp_r);
      end
      pending <= label_q.size();
    end
  end

endmodule

// ===== tb/lldp_tlv_stream_parser_unit_test.sv =====
`timescale 1ns / 1ps
// Top of the LLDP TLV stream parser testbench: clock, reset, frame stimulus and verdict.
// Instantiates lldp_tlv_stream_parser_unit and lldp_label_checker; uses lldp_pkg.
module lldp_tlv_stream_parser_unit_test;
  import lldp_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEG_ITEMS      = 30;

  typedef enum int {FR_WELL, FR_TRUNC, FR_FOREIGN, FR_SHORT} frame_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = '0;
  logic        frame_first = 1'b0;
  logic        frame_last = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  byte_kind;
  logic [7:0]  byte_out;
  logic [2:0]  byte_index;
  logic [6:0]  tlv_kind;
  logic [8:0]  tlv_size;
  logic [8:0]  value_offset;
  logic        value_final;
  logic        is_lldp;
  logic        end_reached;
  logic        truncated;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          items_sent = 0;
  logic        hold_toggle = 1'b0;
  logic [15:0] cur_etype = ETYPE_RESET;

  lldp_tlv_stream_parser_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_byte   (frame_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_kind    (byte_kind),
    .byte_out     (byte_out),
    .byte_index   (byte_index),
    .tlv_kind     (tlv_kind),
    .tlv_size     (tlv_size),
    .value_offset (value_offset),
    .value_final  (value_final),
    .is_lldp      (is_lldp),
    .end_reached  (end_reached),
    .truncated    (truncated)
  );

  lldp_label_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_byte   (frame_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_kind    (byte_kind),
    .byte_out     (byte_out),
    .byte_index   (byte_index),
    .tlv_kind     (tlv_kind),
    .tlv_size     (tlv_size),
    .value_offset (value_offset),
    .value_final  (value_final),
    .is_lldp      (is_lldp),
    .end_reached  (end_reached),
    .truncated    (truncated),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever hold_toggle flips
  initial begin
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  // valid stays up across back-to-back transactions; only gaps lower it
  task automatic send_item(input logic [7:0] b, input logic f, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    frame_byte  <= b;
    frame_first <= f;
    frame_last  <= l;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_cfg(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endtask

  task automatic push_tlv(ref logic [7:0] fbuf[$], input logic [6:0] tk, input int sz);
    logic [8:0] s9;
    s9 = 9'(sz);
    append_byte(fbuf, {tk, s9[8]});
    append_byte(fbuf, s9[7:0]);
    repeat (sz) append_byte(fbuf, rand_byte());
  endtask

  task automatic send_frame(input frame_style_t style, input int long_size);
    logic [7:0]  fbuf[$];
    logic [15:0] et;
    int          sz;
    int          r;
    int          cut;
    bit          drop_first;
    bit          drop_last;
    drop_first = ($urandom_range(99) < 10);
    drop_last  = ($urandom_range(99) < 8);
    repeat (12) append_byte(fbuf, rand_byte());
    et = (style == FR_FOREIGN) ? (cur_etype ^ 16'($urandom_range(1, 65535))) : cur_etype;
    append_byte(fbuf, et[15:8]);
    append_byte(fbuf, et[7:0]);
    if (style == FR_SHORT) begin
      cut = $urandom_range(1, 13);
      while (fbuf.size() > cut) fbuf.pop_back();
    end else if (style == FR_FOREIGN) begin
      repeat ($urandom_range(0, 12)) append_byte(fbuf, rand_byte());
    end else begin
      if (long_size > 0) begin
        push_tlv(fbuf, 7'($urandom_range(1, 127)), long_size);
      end
      repeat ($urandom_range(0, 4)) begin
        r = $urandom_range(99);
        if (r < 20) begin
          sz = 0;
        end else if (r < 80) begin
          sz = $urandom_range(1, 6);
        end else if (r < 95) begin
          sz = $urandom_range(7, 24);
        end else begin
          // in this random pick, declared lengths above 255 only in frames that get cut short
          sz = (style == FR_TRUNC) ? $urandom_range(256, 511) : $urandom_range(25, 60);
        end
        if (style == FR_TRUNC && sz > 60) begin
          append_byte(fbuf, {7'($urandom_range(1, 127)), 1'b1});
          append_byte(fbuf, 8'(sz));
          repeat ($urandom_range(0, 20)) append_byte(fbuf, rand_byte());
        end else begin
          push_tlv(fbuf, 7'($urandom_range(1, 127)), sz);
        end
      end
      if (style == FR_WELL) begin
        // end TLV, sometimes with the length high bit set, then trailing bytes
        append_byte(fbuf, {7'd0, 1'($urandom_range(1))});
        append_byte(fbuf, rand_byte());
        repeat ($urandom_range(0, 3)) append_byte(fbuf, rand_byte());
      end else begin
        cut = 14 + $urandom_range(0, 30);
        while (fbuf.size() > cut) fbuf.pop_back();
      end
    end
    foreach (fbuf[i]) begin
      send_item(fbuf[i], (i == 0) && !drop_first, (i == fbuf.size() - 1) && !drop_last);
    end
  endtask

  initial begin
    logic [7:0]   lldp_frame[23];
    logic [15:0]  seg_etype[5];
    frame_style_t style;
    int           target;
    int           r;
    bit           paused;

    // dst, src, ethertype, zero-length TLV, 2-byte TLV, end TLV, one trailing byte
    lldp_frame = '{8'h01, 8'h80, 8'hC2, 8'h00, 8'h00, 8'h0E,
                   8'h00, 8'hFF, 8'h00, 8'hFF, 8'h12, 8'h34,
                   8'h88, 8'hCC,
                   8'hFE, 8'h00,
                   8'h02, 8'h02, 8'h00, 8'hFF,
                   8'h00, 8'h00,
                   8'hFF};
    seg_etype  = '{ETYPE_RESET, 16'hFFFF, 16'h0000, 16'h0000, ETYPE_RESET};
    seg_etype[3] = 16'($urandom);
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs on the reset ethertype
    send_item(8'hA5, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    foreach (lldp_frame[i]) begin
      send_item(lldp_frame[i], i == 0, i == 22);
    end

    for (int s = 0; s < 5; s++) begin
      wait_drained();
      send_idle_pct <= (s < 2) ? 20 : (s < 4) ? 64 : 0;
      recv_idle_pct <= (s < 2) ? 64 : (s < 4) ? 20 : 0;
      write_cfg(seg_etype[s]);
      cur_etype = seg_etype[s];
      if (s == 1) begin
        hold_toggle <= ~hold_toggle;
      end
      if (s == 4) begin
        send_frame(FR_WELL, 260);
      end
      target = items_sent + SEG_ITEMS;
      while (items_sent < target) begin
        if (s == 2 && !paused && items_sent > target - SEG_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        style = (r < 60) ? FR_WELL : (r < 75) ? FR_TRUNC : (r < 90) ? FR_FOREIGN : FR_SHORT;
        send_frame(style, 0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== lldp_tlv_stream_parser_unit.f =====
src/lldp_pkg.sv
src/lldp_walker.sv
src/lldp_out_reg.sv
src/lldp_tlv_stream_parser_unit.sv
tb/lldp_label_checker.sv
tb/lldp_tlv_stream_parser_unit_test.sv
